// ----- design/fpadt_pkg.sv -----
`timescale 1ns / 1ps
package fpadt_pkg;

  localparam int unsigned AMOUNT_W  = 64;
  localparam int unsigned DEC_W     = 8;
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned DIGIT_IDX_W = 5;
  localparam int unsigned BIT_CNT_W = 6;
  localparam int unsigned TOTAL_W   = 9;
  localparam int unsigned MAX_TEXT  = 44;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 7'h2E;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

  typedef struct packed {
    logic [AMOUNT_W-1:0] amount;
    logic [DEC_W-1:0]    decimals;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
    logic              error;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_ANALYSE,
    ST_CHECK,
    ST_INT,
    ST_POINT,
    ST_FRAC
  } state_e;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_ERROR,
    EMIT_ZERO,
    EMIT_POINT,
    EMIT_DIGIT
  } emit_e;

  typedef enum logic [1:0] {
    POS_HOLD,
    POS_INT,
    POS_FRAC,
    POS_DEC
  } pos_op_e;

  typedef struct packed {
    logic    load;
    logic    shift;
    logic    analyse;
    emit_e   emit_sel;
    logic    emit_last;
    pos_op_e pos_op;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic too_long;
    logic int_present;
    logic have_frac;
    logic pos_at_dec;
    logic pos_at_lo;
  } status_t;

endpackage

// ----- design/fpadt_ctrl.sv -----
`timescale 1ns / 1ps
module fpadt_ctrl import fpadt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '{load: 1'b0, shift: 1'b0, analyse: 1'b0, emit_sel: EMIT_NONE,
              emit_last: 1'b0, pos_op: POS_HOLD};
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.shift = 1'b1;
        if (status_i.conv_done) begin
          state_d = ST_ANALYSE;
        end
      end
      ST_ANALYSE: begin
        cmd_o.analyse = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.too_long) begin
          cmd_o.emit_sel = EMIT_ERROR;
          cmd_o.emit_last = 1'b1;
          state_d = ST_IDLE;
        end else if (status_i.int_present) begin
          cmd_o.pos_op = POS_INT;
          state_d = ST_INT;
        end else begin
          cmd_o.emit_sel = EMIT_ZERO;
          cmd_o.emit_last = !status_i.have_frac;
          state_d = status_i.have_frac ? ST_POINT : ST_IDLE;
        end
      end
      ST_INT: begin
        cmd_o.emit_sel = EMIT_DIGIT;
        if (status_i.pos_at_dec) begin
          cmd_o.emit_last = !status_i.have_frac;
          state_d = status_i.have_frac ? ST_POINT : ST_IDLE;
        end else begin
          cmd_o.pos_op = POS_DEC;
        end
      end
      ST_POINT: begin
        cmd_o.emit_sel = EMIT_POINT;
        cmd_o.pos_op = POS_FRAC;
        state_d = ST_FRAC;
      end
      ST_FRAC: begin
        cmd_o.emit_sel = EMIT_DIGIT;
        if (status_i.pos_at_lo) begin
          cmd_o.emit_last = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.pos_op = POS_DEC;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ----- design/fpadt_dp.sv -----
`timescale 1ns / 1ps
module fpadt_dp import fpadt_pkg::*; #(
  parameter int unsigned TEXT_LIMIT = 44
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  in_t     in_i,
  input  cmd_t    cmd_i,
  output status_t status_o,
  output logic    result_valid_o,
  output out_t    result_o
);

  logic [AMOUNT_W-1:0]        bin_q;
  logic [4*NUM_DIGITS-1:0]    bcd_q;
  logic [4*NUM_DIGITS-1:0]    bcd_adj;
  logic [BIT_CNT_W-1:0]       cnt_q;
  logic [DEC_W-1:0]           dec_q;
  logic [DIGIT_IDX_W-1:0]     ndig_q, ndig_d;
  logic [DIGIT_IDX_W-1:0]     frac_lo_q, frac_lo_d;
  logic                       have_frac_q, have_frac_d;
  logic [DEC_W-1:0]           pos_q;
  logic [NUM_DIGITS-1:0]      nz;
  logic [3:0]                 digit;
  logic [TOTAL_W-1:0]         int_len, frac_len, total;
  logic                       valid_q;
  out_t                       res_q;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
      nz[i] = (bcd_q[4*i +: 4] != 4'd0);
    end
  end

  always_comb begin
    ndig_d = DIGIT_IDX_W'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (nz[i]) begin
        ndig_d = DIGIT_IDX_W'(i + 1);
      end
    end
    frac_lo_d = '0;
    have_frac_d = 1'b0;
    for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
      if (nz[i] && (DEC_W'(i) < dec_q)) begin
        frac_lo_d = DIGIT_IDX_W'(i);
        have_frac_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q <= in_i.amount;
      bcd_q <= '0;
      cnt_q <= '0;
      dec_q <= in_i.decimals;
    end else if (cmd_i.shift) begin
      bcd_q <= {bcd_adj[4*NUM_DIGITS-2:0], bin_q[AMOUNT_W-1]};
      bin_q <= {bin_q[AMOUNT_W-2:0], 1'b0};
      cnt_q <= cnt_q + BIT_CNT_W'(1);
    end
    if (cmd_i.analyse) begin
      ndig_q <= ndig_d;
      frac_lo_q <= frac_lo_d;
      have_frac_q <= have_frac_d;
    end
    unique case (cmd_i.pos_op)
      POS_HOLD: pos_q <= pos_q;
      POS_INT:  pos_q <= DEC_W'(ndig_q) - DEC_W'(1);
      POS_FRAC: pos_q <= dec_q - DEC_W'(1);
      POS_DEC:  pos_q <= pos_q - DEC_W'(1);
      default:  pos_q <= pos_q;
    endcase
  end

  assign status_o.int_present = (DEC_W'(ndig_q) > dec_q);
  assign status_o.have_frac   = have_frac_q;
  assign status_o.conv_done   = (cnt_q == BIT_CNT_W'(AMOUNT_W - 1));
  assign status_o.pos_at_dec  = (pos_q == dec_q);
  assign status_o.pos_at_lo   = (pos_q == DEC_W'(frac_lo_q));

  always_comb begin
    if (status_o.int_present) begin
      int_len = TOTAL_W'(ndig_q) - TOTAL_W'(dec_q);
    end else begin
      int_len = TOTAL_W'(1);
    end
    frac_len = TOTAL_W'(dec_q) - TOTAL_W'(frac_lo_q);
    total = int_len + (have_frac_q ? (frac_len + TOTAL_W'(1)) : '0);
  end

  assign status_o.too_long = (total > TOTAL_W'(TEXT_LIMIT));

  always_comb begin
    if (pos_q < DEC_W'(NUM_DIGITS)) begin
      digit = bcd_q[4*pos_q[DIGIT_IDX_W-1:0] +: 4];
    end else begin
      digit = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (cmd_i.emit_sel != EMIT_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.last  <= cmd_i.emit_last;
    res_q.error <= (cmd_i.emit_sel == EMIT_ERROR);
    unique case (cmd_i.emit_sel)
      EMIT_NONE:  res_q.char_code <= CHAR_NONE;
      EMIT_ERROR: res_q.char_code <= CHAR_NONE;
      EMIT_ZERO:  res_q.char_code <= CHAR_ZERO;
      EMIT_POINT: res_q.char_code <= CHAR_POINT;
      EMIT_DIGIT: res_q.char_code <= CHAR_ZERO + CHAR_W'(digit);
      default:    res_q.char_code <= CHAR_NONE;
    endcase
  end

  assign result_valid_o = valid_q;
  assign result_o = res_q;

endmodule

// ----- design/fixed_point_amount_to_decimal_text_core.sv -----
`timescale 1ns / 1ps
// After start is taken the block runs 64 shift steps, an analysis step and a length check, then
// emits either an error or a lone zero integer digit, or, when the integer part has digits, first
// loads the digit position; each result is registered before it appears on the outputs.
// Busy stays high until the last result of a transaction has been chosen, and the next transaction
// is taken only once busy has fallen; the receiver cannot stall.
// Reset is asynchronous and active low; it returns the controller to idle and clears the strobe.
module fixed_point_amount_to_decimal_text_core import fpadt_pkg::*; #(
  parameter int unsigned OUT_CAPACITY = 45
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  in_i,
  output logic result_valid_o,
  output out_t result_o
);

  localparam int unsigned TEXT_LIMIT =
    ((OUT_CAPACITY - 1) > MAX_TEXT) ? MAX_TEXT : (OUT_CAPACITY - 1);

  cmd_t    cmd;
  status_t status;

  fpadt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  fpadt_dp #(
    .TEXT_LIMIT (TEXT_LIMIT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ----- design/fpadt_checker.sv -----
`timescale 1ns / 1ps
module fpadt_checker import fpadt_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input out_t result_o
);

  // An error transaction is always a single final result with no character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.error) |-> (result_o.last && result_o.char_code == CHAR_NONE))
    else $error("error result not final or carries a character");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.error) |->
      ((result_o.char_code == CHAR_POINT) ||
       ((result_o.char_code >= CHAR_ZERO) && (result_o.char_code <= CHAR_ZERO + 7'd9))))
    else $error("character result is neither a digit nor a point");

  // Characters of one amount follow each other without gaps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |=> result_valid_o)
    else $error("gap inside a character stream");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !result_valid_o))
    else $error("accepted transaction did not make the block busy");

endmodule

bind fixed_point_amount_to_decimal_text_core fpadt_checker u_fpadt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import fpadt_pkg::*;

  localparam int unsigned TEXT_LIMIT     = 44;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 80;
  localparam logic [63:0] AMOUNT_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TEN_POW_19     = 64'd10000000000000000000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  in_i;
  logic result_valid_o;
  out_t result_o;

  out_t expected_text[$];
  int   error_count;
  int   quiet_cycles;

  fixed_point_amount_to_decimal_text_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void expect_char(logic [CHAR_W-1:0] code, logic is_last);
    out_t c;
    c.char_code = code;
    c.last      = is_last;
    c.error     = 1'b0;
    expected_text.push_back(c);
  endfunction

  // Works out the characters that one amount should produce and queues them.
  function automatic void predict_text(in_t item);
    logic [63:0] v;
    int unsigned dig[20];
    int          ndig;
    int          dec;
    int          int_len;
    int          frac_lo;
    int          frac_len;
    int          total;
    int          p;
    int          k;
    bit          have_frac;
    out_t        err;
    v         = item.amount;
    dec       = int'(item.decimals);
    ndig      = 0;
    have_frac = 1'b0;
    frac_lo   = 0;
    for (int i = 0; i < 20; i++) dig[i] = 0;
    do begin
      dig[ndig] = int'(v % 64'd10);
      v         = v / 64'd10;
      ndig++;
    end while (v != 0 && ndig < 20);
    int_len = (ndig > dec) ? ndig - dec : 1;
    for (p = 0; p < dec && p < 20; p++) begin
      if (dig[p] != 0) begin
        frac_lo   = p;
        have_frac = 1'b1;
        break;
      end
    end
    frac_len = have_frac ? dec - frac_lo : 0;
    total    = int_len + (have_frac ? 1 + frac_len : 0);
    if (total > TEXT_LIMIT) begin
      err.char_code = CHAR_NONE;
      err.last      = 1'b1;
      err.error     = 1'b1;
      expected_text.push_back(err);
      return;
    end
    k = 0;
    if (ndig > dec) begin
      for (p = ndig - 1; p >= dec; p--) begin
        k++;
        expect_char(CHAR_ZERO + CHAR_W'(dig[p]), k == total);
      end
    end else begin
      k++;
      expect_char(CHAR_ZERO, k == total);
    end
    if (have_frac) begin
      k++;
      expect_char(CHAR_POINT, k == total);
      for (p = dec - 1; p >= frac_lo; p--) begin
        k++;
        expect_char(CHAR_ZERO + CHAR_W'((p < 20) ? dig[p] : 0), k == total);
      end
    end
  endfunction

  function automatic void note_failure(string msg);
    if (error_count < 10) $display("%0t: %s", $realtime, msg);
    error_count++;
  endfunction

  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_text.size() == 0) begin
        note_failure($sformatf("unexpected result char=%02h last=%0b error=%0b",
                               result_o.char_code, result_o.last, result_o.error));
      end else begin
        want = expected_text.pop_front();
        if (want.char_code !== result_o.char_code || want.last !== result_o.last ||
            want.error !== result_o.error) begin
          note_failure($sformatf(
            "mismatch: expected char=%02h last=%0b error=%0b, got char=%02h last=%0b error=%0b",
            want.char_code, want.last, want.error,
            result_o.char_code, result_o.last, result_o.error));
        end
      end
    end
  end

  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || result_valid_o) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Called at a rising edge; returns at a rising edge. Start is left high only when
  // another transaction follows straight away.
  task automatic send_amount(logic [63:0] amount, logic [7:0] decimals, int idle_pct);
    in_t item;
    item.amount   = amount;
    item.decimals = decimals;
    start <= 1'b1;
    in_i  <= item;
    do @(posedge clk_i); while (busy);
    predict_text(item);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 130)) @(posedge clk_i);
    end
  endtask

  task automatic wait_text_drained();
    start <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_integer_text();
    send_amount(64'd0, 8'd0, 0);
    send_amount(64'd9, 8'd0, 0);
    send_amount(64'd10, 8'd0, 0);
    send_amount(64'd1, 8'd0, 0);
    send_amount(TEN_POW_19, 8'd0, 0);
    send_amount(AMOUNT_MAX, 8'd0, 0);
  endtask

  task automatic test_fraction_text();
    send_amount(64'd12345, 8'd2, 0);
    send_amount(64'd12300, 8'd2, 0);
    send_amount(64'd12340, 8'd2, 0);
    send_amount(64'd100, 8'd3, 0);
    send_amount(64'd5, 8'd1, 0);
    send_amount(64'd1000, 8'd3, 0);
    send_amount(64'd0, 8'd255, 0);
    send_amount(AMOUNT_MAX, 8'd19, 0);
    send_amount(AMOUNT_MAX, 8'd20, 0);
    send_amount(TEN_POW_19, 8'd19, 0);
    send_amount(TEN_POW_19, 8'd20, 0);
    send_amount(64'd1, 8'd42, 0);
    send_amount(64'd7, 8'd22, 0);
  endtask

  task automatic test_overflow_error();
    send_amount(64'd1, 8'd43, 0);
    send_amount(AMOUNT_MAX, 8'd43, 0);
    send_amount(AMOUNT_MAX, 8'd255, 0);
    send_amount(64'd3, 8'd200, 0);
    wait_text_drained();
  endtask

  task automatic test_random_amounts(int count, int idle_pct);
    logic [63:0] amount;
    logic [63:0] scale;
    logic [7:0]  decimals;
    repeat (count) begin
      amount = {$urandom, $urandom} >> $urandom_range(0, 63);
      scale  = 64'd1;
      repeat ($urandom_range(0, 12)) scale = scale * 64'd10;
      case ($urandom_range(9))
        0: begin
          amount   = {$urandom, $urandom};
          decimals = 8'($urandom_range(0, 255));
        end
        1, 2, 3: decimals = 8'($urandom_range(0, 24));
        4, 5: begin
          amount   = 64'($urandom_range(0, 99999)) * scale;
          decimals = 8'($urandom_range(0, 22));
        end
        6, 7: decimals = 8'($urandom_range(20, 46));
        8: begin
          amount   = $urandom_range(1) ? scale : 64'd0;
          decimals = 8'($urandom_range(0, 255));
        end
        default: begin
          amount   = {$urandom, $urandom};
          decimals = 8'($urandom_range(0, 20));
        end
      endcase
      send_amount(amount, decimals, idle_pct);
    end
    wait_text_drained();
  endtask

  task automatic test_drain_pause();
    repeat (3) send_amount({$urandom, $urandom}, 8'($urandom_range(0, 20)), 0);
    wait_text_drained();
    repeat (3) send_amount({$urandom, $urandom}, 8'($urandom_range(0, 20)), 0);
    wait_text_drained();
  endtask

  initial begin
    error_count = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    in_i        = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_integer_text();
    test_fraction_text();
    test_overflow_error();
    test_random_amounts(110, 0);
    test_random_amounts(110, 62);
    test_drain_pause();
    test_random_amounts(110, 0);
    test_random_amounts(110, 20);
    wait_text_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
